>>> hdl/takf_pkg.sv
package takf_pkg;

   // fixed field widths and fixed-point format
   localparam int CFG_WIDTH       = 48;
   localparam int IO_WIDTH        = 32;
   localparam int FRAC_BITS       = 44;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIME_STEP   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_NOISE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BIAS_NOISE  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEAS_NOISE  = 2'd3;

   // register reset values (Q4.44)
   localparam logic [CFG_WIDTH-1:0] TIME_STEP_RST   = 48'd175921860444;
   localparam logic [CFG_WIDTH-1:0] ANGLE_NOISE_RST = 48'd17592186044;
   localparam logic [CFG_WIDTH-1:0] BIAS_NOISE_RST  = 48'd52776558133;
   localparam logic [CFG_WIDTH-1:0] MEAS_NOISE_RST  = 48'd527765581332;

   // datapath micro-operations, in execution order (an update skips OP_SETA, which only set angle uses)
   typedef enum logic [4:0] {
      OP_LOAD,
      OP_SETA,
      OP_RATE,
      OP_PRED_ANG,
      OP_T,
      OP_INN1,
      OP_INN2,
      OP_INN3,
      OP_C0P,
      OP_C12P,
      OP_C3P,
      OP_S,
      OP_GAIN,
      OP_Y,
      OP_ANG_C,
      OP_BIAS_C,
      OP_C0C,
      OP_C1C,
      OP_C2C,
      OP_C3C,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } sts_type;

   function automatic logic is_mul(input op_type op);
      logic r;
      case (op)
         OP_PRED_ANG, OP_T, OP_C0P, OP_C3P, OP_ANG_C, OP_BIAS_C,
         OP_C0C, OP_C1C, OP_C2C, OP_C3C: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic op_type next_op(input op_type op);
      op_type r;
      case (op)
         OP_RATE:     r = OP_PRED_ANG;
         OP_PRED_ANG: r = OP_T;
         OP_T:        r = OP_INN1;
         OP_INN1:     r = OP_INN2;
         OP_INN2:     r = OP_INN3;
         OP_INN3:     r = OP_C0P;
         OP_C0P:      r = OP_C12P;
         OP_C12P:     r = OP_C3P;
         OP_C3P:      r = OP_S;
         OP_S:        r = OP_GAIN;
         OP_GAIN:     r = OP_Y;
         OP_Y:        r = OP_ANG_C;
         OP_ANG_C:    r = OP_BIAS_C;
         OP_BIAS_C:   r = OP_C0C;
         OP_C0C:      r = OP_C1C;
         OP_C1C:      r = OP_C2C;
         OP_C2C:      r = OP_C3C;
         default:     r = OP_EMIT;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/takf_req_if.sv
interface takf_req_if;
   import takf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic signed [IO_WIDTH-1:0] measured_angle;
   logic signed [IO_WIDTH-1:0] measured_rate;

   modport source (output valid, action, measured_angle, measured_rate, input ready);
   modport sink (input valid, action, measured_angle, measured_rate, output ready);
endinterface

>>> hdl/takf_rsp_if.sv
interface takf_rsp_if;
   import takf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] angle;
   logic signed [IO_WIDTH-1:0] unbiased_rate;

   modport source (output valid, angle, unbiased_rate, input ready);
   modport sink (input valid, angle, unbiased_rate, output ready);
endinterface

>>> hdl/takf_mul.sv
module takf_mul import takf_pkg::*; #(
   parameter int OW = 64,
   parameter int AW = 32,
   parameter int CW = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 wide,
   input  logic signed [OW-1:0] a,
   input  logic signed [OW-1:0] b,
   output logic                 done,
   output logic signed [OW-1:0] result
);

   localparam int NC   = (OW + 31) / 32;
   localparam int XW   = NC * 32;
   localparam int PW   = 2 * XW + 1;
   localparam int MAGW = PW - FRAC_BITS;
   localparam int IW   = (NC > 1) ? $clog2(NC) : 1;
   localparam int SHW  = (NC > 1) ? $clog2(2 * NC - 1) : 1;

   localparam logic [MAGW-1:0] APOS = (MAGW'(1) << (AW - 1)) - MAGW'(1);
   localparam logic [MAGW-1:0] ANEG = MAGW'(1) << (AW - 1);
   localparam logic [MAGW-1:0] CPOS = (MAGW'(1) << (CW - 1)) - MAGW'(1);
   localparam logic [MAGW-1:0] CNEG = MAGW'(1) << (CW - 1);
   localparam logic [PW-1:0]   HALF = PW'(1) << (FRAC_BITS - 1);

   logic                 iss_ff, iss_in;
   logic                 vld_ff, vld_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic                 wide_ff, wide_in;
   logic [IW-1:0]        ci_ff, ci_in;
   logic [IW-1:0]        cj_ff, cj_in;
   logic [XW-1:0]        ma_ff, ma_in;
   logic [XW-1:0]        mb_ff, mb_in;
   logic [63:0]          pp_ff, pp_in;
   logic [SHW-1:0]       sh_ff, sh_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic signed [OW-1:0] res_ff, res_in;

   logic [OW-1:0]        abs_a, abs_b;
   logic [31:0]          chunk_a, chunk_b;
   logic [PW-1:0]        rnd;
   logic [MAGW-1:0]      mag, lim, msat;

   assign abs_a   = a[OW-1] ? OW'(-a) : OW'(a);
   assign abs_b   = b[OW-1] ? OW'(-b) : OW'(b);
   assign chunk_a = ma_ff[32 * int'(ci_ff) +: 32];
   assign chunk_b = mb_ff[32 * int'(cj_ff) +: 32];

   // round half away from zero, then saturate the magnitude
   assign rnd  = acc_ff + HALF;
   assign mag  = rnd[PW-1:FRAC_BITS];
   assign lim  = wide_ff ? (neg_ff ? CNEG : CPOS) : (neg_ff ? ANEG : APOS);
   assign msat = (mag > lim) ? lim : mag;

   always_comb begin
      iss_in  = iss_ff;
      vld_in  = iss_ff;
      fin_in  = vld_ff & ~iss_ff;
      done_in = fin_ff;
      neg_in  = neg_ff;
      wide_in = wide_ff;
      ci_in   = ci_ff;
      cj_in   = cj_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      // operand capture
      if (start) begin
         iss_in  = 1'b1;
         vld_in  = 1'b0;
         fin_in  = 1'b0;
         neg_in  = a[OW-1] ^ b[OW-1];
         wide_in = wide;
         ci_in   = '0;
         cj_in   = '0;
         ma_in   = XW'(abs_a);
         mb_in   = XW'(abs_b);
         acc_in  = '0;
      end else begin
         // one 32x32 partial product per cycle
         if (iss_ff) begin
            pp_in = 64'(chunk_a) * 64'(chunk_b);
            sh_in = SHW'(ci_ff) + SHW'(cj_ff);
            if (int'(cj_ff) == NC - 1) begin
               cj_in = '0;
               if (int'(ci_ff) == NC - 1) begin
                  iss_in = 1'b0;
               end else begin
                  ci_in = ci_ff + IW'(1);
               end
            end else begin
               cj_in = cj_ff + IW'(1);
            end
         end
         // accumulate the registered partial product
         if (vld_ff) begin
            acc_in = acc_ff + (PW'(pp_ff) << (32 * int'(sh_ff)));
         end
         if (fin_ff) begin
            res_in = neg_ff ? OW'(-msat[OW-1:0]) : OW'(msat[OW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff  <= 1'b0;
         vld_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iss_ff  <= iss_in;
         vld_ff  <= vld_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      wide_ff <= wide_in;
      ci_ff   <= ci_in;
      cj_ff   <= cj_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      pp_ff   <= pp_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> hdl/takf_div.sv
module takf_div import takf_pkg::*; #(
   parameter int CW = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [CW-1:0] num0,
   input  logic signed [CW-1:0] num1,
   input  logic signed [CW-1:0] den,
   output logic                 done,
   output logic signed [CW-1:0] quo0,
   output logic signed [CW-1:0] quo1
);

   localparam int DW   = CW + FRAC_BITS;
   localparam int CNTW = $clog2(DW + 1);
   localparam logic [DW-1:0] QPOS = (DW'(1) << (CW - 1)) - DW'(1);
   localparam logic [DW-1:0] QNEG = DW'(1) << (CW - 1);

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic                 dz_ff, dz_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]        ud_ff, ud_in;
   logic                 neg_ff [2];
   logic                 neg_in [2];
   logic [DW-1:0]        num_ff [2];
   logic [DW-1:0]        num_in [2];
   logic [CW-1:0]        rem_ff [2];
   logic [CW-1:0]        rem_in [2];
   logic [DW-1:0]        q_ff   [2];
   logic [DW-1:0]        q_in   [2];
   logic signed [CW-1:0] res_ff [2];
   logic signed [CW-1:0] res_in [2];

   logic signed [CW-1:0] nsrc [2];
   logic [CW:0]          rsh  [2];
   logic                 ge   [2];
   logic [DW-1:0]        lim  [2];
   logic [DW-1:0]        qsat [2];

   assign nsrc[0] = num0;
   assign nsrc[1] = num1;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      dz_in   = dz_ff;
      cnt_in  = cnt_ff;
      ud_in   = ud_ff;
      if (start) begin
         busy_in = 1'b1;
         dz_in   = (den == '0);
         cnt_in  = CNTW'(DW);
         ud_in   = den[CW-1] ? CW'(-den) : CW'(den);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      // two restoring division lanes sharing one divisor
      for (int k = 0; k < 2; k++) begin
         rsh[k]    = {rem_ff[k], num_ff[k][DW-1]};
         ge[k]     = (rsh[k] >= {1'b0, ud_ff});
         lim[k]    = neg_ff[k] ? QNEG : QPOS;
         qsat[k]   = (q_ff[k] > lim[k]) ? lim[k] : q_ff[k];
         neg_in[k] = neg_ff[k];
         num_in[k] = num_ff[k];
         rem_in[k] = rem_ff[k];
         q_in[k]   = q_ff[k];
         res_in[k] = res_ff[k];
         if (start) begin
            neg_in[k] = nsrc[k][CW-1] ^ den[CW-1];
            // magnitude is unsigned so the most negative numerator stays 2^(CW-1)
            num_in[k] = DW'($unsigned(nsrc[k][CW-1] ? -nsrc[k] : nsrc[k])) << FRAC_BITS;
            rem_in[k] = '0;
            q_in[k]   = '0;
         end else if (busy_ff) begin
            num_in[k] = num_ff[k] << 1;
            rem_in[k] = ge[k] ? CW'(rsh[k] - {1'b0, ud_ff}) : CW'(rsh[k]);
            q_in[k]   = {q_ff[k][DW-2:0], ge[k]};
         end else if (fin_ff) begin
            if (dz_ff) begin
               res_in[k] = '0;
            end else begin
               res_in[k] = neg_ff[k] ? CW'(-qsat[k][CW-1:0]) : CW'(qsat[k][CW-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      dz_ff  <= dz_in;
      cnt_ff <= cnt_in;
      ud_ff  <= ud_in;
      for (int k = 0; k < 2; k++) begin
         neg_ff[k] <= neg_in[k];
         num_ff[k] <= num_in[k];
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
         res_ff[k] <= res_in[k];
      end
   end

   assign done = done_ff;
   assign quo0 = res_ff[0];
   assign quo1 = res_ff[1];

endmodule

>>> hdl/takf_datapath.sv
module takf_datapath import takf_pkg::*; #(
   parameter int AW = 32,
   parameter int CW = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data,
   input  logic signed [IO_WIDTH-1:0] in_angle,
   input  logic signed [IO_WIDTH-1:0] in_rate,
   output logic signed [IO_WIDTH-1:0] out_angle,
   output logic signed [IO_WIDTH-1:0] out_rate
);

   localparam int OW = (AW > CW) ? ((AW > 49) ? AW : 49) : ((CW > 49) ? CW : 49);
   localparam int SW = OW + 1;

   localparam logic signed [SW-1:0] AMAX = (SW'(1) <<< (AW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] AMIN = -AMAX - SW'(1);
   localparam logic signed [SW-1:0] CMAX = (SW'(1) <<< (CW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
   localparam logic signed [SW-1:0] OMAX = (SW'(1) <<< (IO_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0] OMIN = -OMAX - SW'(1);

   function automatic logic signed [SW-1:0] xa(input logic signed [AW-1:0] v);
      return SW'(v);
   endfunction

   function automatic logic signed [SW-1:0] xc(input logic signed [CW-1:0] v);
      return SW'(v);
   endfunction

   function automatic logic signed [SW-1:0] xu(input logic [CFG_WIDTH-1:0] v);
      return SW'(v);
   endfunction

   function automatic logic signed [SW-1:0] xi(input logic signed [IO_WIDTH-1:0] v);
      return SW'(v);
   endfunction

   function automatic logic signed [AW-1:0] sat_a(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v > AMAX) ? AMAX : ((v < AMIN) ? AMIN : v);
      return r[AW-1:0];
   endfunction

   function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
      return r[CW-1:0];
   endfunction

   function automatic logic signed [IO_WIDTH-1:0] sat_o(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v > OMAX) ? OMAX : ((v < OMIN) ? OMIN : v);
      return r[IO_WIDTH-1:0];
   endfunction

   // configuration registers
   logic [CFG_WIDTH-1:0] dt_ff, qa_ff, qb_ff, rm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= TIME_STEP_RST;
         qa_ff <= ANGLE_NOISE_RST;
         qb_ff <= BIAS_NOISE_RST;
         rm_ff <= MEAS_NOISE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TIME_STEP:   dt_ff <= csr_write_data;
            REG_ANGLE_NOISE: qa_ff <= csr_write_data;
            REG_BIAS_NOISE:  qb_ff <= csr_write_data;
            REG_MEAS_NOISE:  rm_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // filter state and scratch registers
   logic signed [AW-1:0]       ang_ff, ang_in, bias_ff, bias_in, lrate_ff, lrate_in;
   logic signed [AW-1:0]       mang_ff, mang_in, mrate_ff, mrate_in, y_ff, y_in;
   logic signed [CW-1:0]       c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic signed [CW-1:0]       t_ff, t_in, inner_ff, inner_in, s_ff, s_in;
   logic signed [CW-1:0]       g0_ff, g0_in, g1_ff, g1_in, c00_ff, c00_in, c01_ff, c01_in;
   logic signed [IO_WIDTH-1:0] oang_ff, oang_in, orate_ff, orate_in;

   // shared multiplier and gain divider
   logic                 mul_start, mul_wide, mul_done;
   logic signed [OW-1:0] mul_a, mul_b, mul_res;
   logic signed [AW-1:0] pa;
   logic signed [CW-1:0] pc;
   logic                 div_start, div_done;
   logic signed [CW-1:0] q0, q1;

   assign mul_start = cmd.go & is_mul(cmd.op);
   assign div_start = cmd.go & (cmd.op == OP_GAIN);
   assign pa        = mul_res[AW-1:0];
   assign pc        = mul_res[CW-1:0];

   // multiplier operand selection
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mul_wide = 1'b1;
      case (cmd.op)
         OP_PRED_ANG: begin
            mul_a = OW'(dt_ff); mul_b = OW'(lrate_ff); mul_wide = 1'b0;
         end
         OP_T:      begin mul_a = OW'(dt_ff); mul_b = OW'(c3_ff);    end
         OP_C0P:    begin mul_a = OW'(dt_ff); mul_b = OW'(inner_ff); end
         OP_C3P:    begin mul_a = OW'(qb_ff); mul_b = OW'(dt_ff);    end
         OP_ANG_C:  begin mul_a = OW'(g0_ff); mul_b = OW'(y_ff); mul_wide = 1'b0; end
         OP_BIAS_C: begin mul_a = OW'(g1_ff); mul_b = OW'(y_ff); mul_wide = 1'b0; end
         OP_C0C:    begin mul_a = OW'(g0_ff); mul_b = OW'(c00_ff); end
         OP_C1C:    begin mul_a = OW'(g0_ff); mul_b = OW'(c01_ff); end
         OP_C2C:    begin mul_a = OW'(g1_ff); mul_b = OW'(c00_ff); end
         OP_C3C:    begin mul_a = OW'(g1_ff); mul_b = OW'(c01_ff); end
         default: ;
      endcase
   end

   takf_mul #(.OW(OW), .AW(AW), .CW(CW)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .wide   (mul_wide),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   takf_div #(.CW(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num0  (c0_ff),
      .num1  (c2_ff),
      .den   (s_ff),
      .done  (div_done),
      .quo0  (q0),
      .quo1  (q1)
   );

   // steps done without the multiplier or divider, multiplier write-back, gain capture
   always_comb begin
      ang_in = ang_ff;   bias_in = bias_ff;   lrate_in = lrate_ff;
      mang_in = mang_ff; mrate_in = mrate_ff; y_in = y_ff;
      c0_in = c0_ff; c1_in = c1_ff; c2_in = c2_ff; c3_in = c3_ff;
      t_in = t_ff; inner_in = inner_ff; s_in = s_ff;
      g0_in = g0_ff; g1_in = g1_ff; c00_in = c00_ff; c01_in = c01_ff;
      oang_in = oang_ff; orate_in = orate_ff;
      if (cmd.go) begin
         case (cmd.op)
            OP_LOAD: begin
               mang_in  = sat_a(xi(in_angle));
               mrate_in = sat_a(xi(in_rate));
            end
            OP_SETA: ang_in   = mang_ff;
            OP_RATE: lrate_in = sat_a(xa(mrate_ff) - xa(bias_ff));
            OP_INN1: inner_in = sat_c(xc(t_ff) - xc(c1_ff));
            OP_INN2: inner_in = sat_c(xc(inner_ff) - xc(c2_ff));
            OP_INN3: inner_in = sat_c(xc(inner_ff) + xc(sat_c(xu(qa_ff))));
            OP_C12P: begin
               c1_in = sat_c(xc(c1_ff) - xc(t_ff));
               c2_in = sat_c(xc(c2_ff) - xc(t_ff));
            end
            OP_S: s_in = sat_c(xc(c0_ff) + xc(sat_c(xu(rm_ff))));
            OP_Y: begin
               y_in   = sat_a(xa(mang_ff) - xa(ang_ff));
               c00_in = c0_ff;
               c01_in = c1_ff;
            end
            OP_EMIT: begin
               oang_in  = sat_o(xa(ang_ff));
               orate_in = sat_o(xa(lrate_ff));
            end
            default: ;
         endcase
      end
      if (mul_done) begin
         case (cmd.op)
            OP_PRED_ANG: ang_in  = sat_a(xa(ang_ff) + xa(pa));
            OP_T:        t_in    = pc;
            OP_C0P:      c0_in   = sat_c(xc(c0_ff) + xc(pc));
            OP_C3P:      c3_in   = sat_c(xc(c3_ff) + xc(pc));
            OP_ANG_C:    ang_in  = sat_a(xa(ang_ff) + xa(pa));
            OP_BIAS_C:   bias_in = sat_a(xa(bias_ff) + xa(pa));
            OP_C0C:      c0_in   = sat_c(xc(c0_ff) - xc(pc));
            OP_C1C:      c1_in   = sat_c(xc(c1_ff) - xc(pc));
            OP_C2C:      c2_in   = sat_c(xc(c2_ff) - xc(pc));
            OP_C3C:      c3_in   = sat_c(xc(c3_ff) - xc(pc));
            default: ;
         endcase
      end
      if (div_done) begin
         g0_in = q0;
         g1_in = q1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff   <= '0;
         bias_ff  <= '0;
         lrate_ff <= '0;
         c0_ff    <= '0;
         c1_ff    <= '0;
         c2_ff    <= '0;
         c3_ff    <= '0;
      end else begin
         ang_ff   <= ang_in;
         bias_ff  <= bias_in;
         lrate_ff <= lrate_in;
         c0_ff    <= c0_in;
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
         c3_ff    <= c3_in;
      end
      mang_ff  <= mang_in;
      mrate_ff <= mrate_in;
      y_ff     <= y_in;
      t_ff     <= t_in;
      inner_ff <= inner_in;
      s_ff     <= s_in;
      g0_ff    <= g0_in;
      g1_ff    <= g1_in;
      c00_ff   <= c00_in;
      c01_ff   <= c01_in;
      oang_ff  <= oang_in;
      orate_ff <= orate_in;
   end

   assign sts.mul_done = mul_done;
   assign sts.div_done = div_done;
   assign out_angle    = oang_ff;
   assign out_rate     = orate_ff;

endmodule

>>> hdl/takf_ctrl.sv
module takf_ctrl import takf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_MWAIT = 4'b0100,
      ST_DWAIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   op_type    step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = step_ff;
      cmd.go       = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // take inputs; result register may still be occupied
            req_ready = 1'b1;
            cmd.op    = OP_LOAD;
            if (req_valid) begin
               cmd.go   = 1'b1;
               step_in  = req_action ? OP_SETA : OP_RATE;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (step_ff == OP_EMIT) begin
               // load result register once it is free
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.go       = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.go = 1'b1;
               if (is_mul(step_ff)) begin
                  state_in = ST_MWAIT;
               end else if (step_ff == OP_GAIN) begin
                  state_in = ST_DWAIT;
               end else begin
                  step_in = next_op(step_ff);
               end
            end
         end
         ST_MWAIT: begin
            if (sts.mul_done) begin
               step_in  = next_op(step_ff);
               state_in = ST_EXEC;
            end
         end
         ST_DWAIT: begin
            if (sts.div_done) begin
               step_in  = next_op(step_ff);
               state_in = ST_EXEC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= OP_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/tilt_angle_kalman_filter.sv
// Tilt-angle Kalman filter: fuses an accelerometer angle with a gyro rate,
// tracking angle and gyro bias (Q16.16) with a 2x2 covariance (Q4.44).
// Channels: req_if carries action (0 = update, 1 = set angle),
// measured_angle and measured_rate; rsp_if returns angle and
// unbiased_rate. Both are valid/ready; a transfer happens when both are high.
// csr_* writes the four tuning registers (time step, angle noise, bias noise,
// measurement noise), one per cycle; the user must write them only while the
// block is idle, and the block itself does not enforce this. A set-angle item
// loads its inputs, copies the measured angle into the state and emits; an
// update's duration is set by the gain divider (COV_WIDTH + 44 iterations,
// one quotient bit a cycle) and ten passes through the shared 32x32
// partial-product multiplier. One item is in work at a time, so a new item is
// taken only after the last one has loaded the result register.
// Reset clears angle, bias, last rate and covariance, and loads the register
// defaults. A finished result waits in the output register while the next
// item is taken; if the receiver stalls, the following result holds in the
// datapath until the register frees.
module tilt_angle_kalman_filter import takf_pkg::*; #(
   parameter int ANGLE_WIDTH = 32,
   parameter int COV_WIDTH   = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   takf_req_if.sink                   req_if,
   takf_rsp_if.source                 rsp_if,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   takf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .cmd        (cmd),
      .sts        (sts)
   );

   takf_datapath #(.AW(ANGLE_WIDTH), .CW(COV_WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .in_angle       (req_if.measured_angle),
      .in_rate        (req_if.measured_rate),
      .out_angle      (rsp_if.angle),
      .out_rate       (rsp_if.unbiased_rate)
   );

endmodule
